// File: sv/bracket_nesting_checker_core_defines.svh
// Assertion macros for the bracket nesting checker.
`ifndef BRACKET_NESTING_CHECKER_CORE_DEFINES_SVH
`define BRACKET_NESTING_CHECKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define BNC_ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("bracket checker assertion failed");
`define BNC_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("bracket checker assertion failed");
`else
`define BNC_ASSERT_IMPL(label, clk, rst, a, b)
`define BNC_ASSERT_NEXT(label, clk, rst, a, b)
`endif

`endif

// File: sv/bnc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bnc_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] CHAR_ROUND_OPEN   = 8'h28;
  localparam logic [7:0] CHAR_ROUND_CLOSE  = 8'h29;
  localparam logic [7:0] CHAR_SQUARE_OPEN  = 8'h5B;
  localparam logic [7:0] CHAR_SQUARE_CLOSE = 8'h5D;
  localparam logic [7:0] CHAR_CURLY_OPEN   = 8'h7B;
  localparam logic [7:0] CHAR_CURLY_CLOSE  = 8'h7D;

  typedef enum logic [1:0] {
    KIND_ROUND,
    KIND_SQUARE,
    KIND_CURLY,
    KIND_NONE
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_BALANCED,
    STATUS_MISMATCH,
    STATUS_UNCLOSED,
    STATUS_OVERFLOW
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP
  } cell_op_t;

  function automatic kind_t opener_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CHAR_ROUND_OPEN:  k = KIND_ROUND;
      CHAR_SQUARE_OPEN: k = KIND_SQUARE;
      CHAR_CURLY_OPEN:  k = KIND_CURLY;
      default:          k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_t closer_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CHAR_ROUND_CLOSE:  k = KIND_ROUND;
      CHAR_SQUARE_CLOSE: k = KIND_SQUARE;
      CHAR_CURLY_CLOSE:  k = KIND_CURLY;
      default:           k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// File: sv/bnc_char_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface bnc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface
`default_nettype wire

// File: sv/bnc_status_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface bnc_status_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;

  modport source (output valid, output status, input ready);
  modport sink (input valid, input status, output ready);
endinterface
`default_nettype wire

// File: sv/bnc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module bnc_cell
  import bnc_pkg::*;
(
  input  wire logic clk,
  input  cell_op_t  op,
  input  kind_t     from_above,
  input  kind_t     from_below,
  output kind_t     kind
);

  always_ff @(posedge clk) begin
    case (op)
      CELL_PUSH: kind <= from_above;
      CELL_POP:  kind <= from_below;
      default:   kind <= kind;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/bracket_nesting_checker_core.sv
// Bracket nesting checker.
// Channel chars (sink) carries one byte per transfer plus a last flag that
// ends a string. Channel result (source) carries one 2-bit status per string:
// 0 balanced, 1 mismatched or unexpected closer, 2 unclosed opener,
// 3 stack overflow. Bytes other than the six brackets are ignored.
// Throughput: one byte per cycle while the status output is not stalled. Each
// byte does at most one push or pop on a row of STACK_DEPTH shift cells; the
// top cell is compared directly, so the whole step is decided combinationally.
// The status enters the output register at the transfer of the last byte and is
// offered on result in the next cycle.
// The first error of a string latches; later bytes do nothing until the
// last byte, which reports it and clears level and error for the next string.
// Reset clears the level, the error and the output valid; cell contents are
// not cleared and are only read while the level counts them.
// When the receiver stalls, the status is held and chars.ready stays low for
// every byte until the status is taken; a byte may transfer in the same cycle
// as the status.
`timescale 1ns / 1ps
`default_nettype none
`include "bracket_nesting_checker_core_defines.svh"
module bracket_nesting_checker_core
  import bnc_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  bnc_char_if.sink     chars,
  bnc_status_if.source result
);

  kind_t              stack [STACK_DEPTH];
  cell_op_t           op;
  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] level_next;
  logic [LEVEL_W-1:0] level_step;
  status_t            err;
  status_t            err_next;
  status_t            err_step;
  status_t            status_next;
  logic               out_valid;
  logic [1:0]         out_status;
  logic               take;
  logic               take_last;
  kind_t              open_k;
  kind_t              close_k;

  assign chars.ready   = !out_valid || result.ready;
  assign take          = chars.valid && chars.ready;
  assign take_last     = take && chars.last;
  assign open_k        = opener_kind(chars.character);
  assign close_k       = closer_kind(chars.character);
  assign result.valid  = out_valid;
  assign result.status = out_status;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    kind_t above;
    kind_t below;
    if (i == 0) begin : g_top
      assign above = open_k;
    end else begin : g_mid
      assign above = stack[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign below = stack[i];
    end else begin : g_inner
      assign below = stack[i+1];
    end
    bnc_cell u_cell (
      .clk        (clk),
      .op         (op),
      .from_above (above),
      .from_below (below),
      .kind       (stack[i])
    );
  end

  always_comb begin
    op         = CELL_HOLD;
    level_step = level;
    err_step   = err;
    if (take && err == STATUS_BALANCED) begin
      if (open_k != KIND_NONE) begin
        if (level == LEVEL_W'(STACK_DEPTH)) begin
          err_step = STATUS_OVERFLOW;
        end else begin
          op         = CELL_PUSH;
          level_step = level + LEVEL_W'(1);
        end
      end else if (close_k != KIND_NONE) begin
        if (level == '0 || stack[0] != close_k) begin
          err_step = STATUS_MISMATCH;
        end else begin
          op         = CELL_POP;
          level_step = level - LEVEL_W'(1);
        end
      end
    end
  end

  always_comb begin
    if (err_step != STATUS_BALANCED) begin
      status_next = err_step;
    end else if (level_step != '0) begin
      status_next = STATUS_UNCLOSED;
    end else begin
      status_next = STATUS_BALANCED;
    end
    if (take_last) begin
      level_next = '0;
      err_next   = STATUS_BALANCED;
    end else begin
      level_next = level_step;
      err_next   = err_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level     <= '0;
      err       <= STATUS_BALANCED;
      out_valid <= 1'b0;
    end else begin
      level <= level_next;
      err   <= err_next;
      if (take_last) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_last) begin
      out_status <= status_next;
    end
  end

  `BNC_ASSERT_IMPL(a_level_range, clk, rst, 1'b1, level <= LEVEL_W'(STACK_DEPTH))
  `BNC_ASSERT_NEXT(a_last_gives_result, clk, rst, take_last, out_valid)
  `BNC_ASSERT_NEXT(a_last_clears, clk, rst, take_last, level == '0 && err == STATUS_BALANCED)
  `BNC_ASSERT_NEXT(a_error_latched, clk, rst, err != STATUS_BALANCED && !take_last, $stable(err))
  `BNC_ASSERT_NEXT(a_level_frozen, clk, rst, err != STATUS_BALANCED && !take_last, $stable(level))

endmodule
`default_nettype wire

// File: tb/sv/bracket_status_checker.sv
`timescale 1ns / 1ps
module bracket_status_checker
  import bnc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  bnc_char_if       chars,
  bnc_status_if     result,
  output int        fails,
  output int        waiting
);

  kind_t       nest_stack [STACK_DEPTH];
  int unsigned nest_level;
  status_t     latched_err;
  status_t     status_queue [$];
  status_t     oldest;

  task automatic apply_byte(input logic [7:0] c, input logic l);
    kind_t k;
    bit    opener;
    bit    closer;
    opener = 1'b0;
    closer = 1'b0;
    k      = KIND_NONE;
    case (c)
      CHAR_ROUND_OPEN: begin
        opener = 1'b1;
        k      = KIND_ROUND;
      end
      CHAR_SQUARE_OPEN: begin
        opener = 1'b1;
        k      = KIND_SQUARE;
      end
      CHAR_CURLY_OPEN: begin
        opener = 1'b1;
        k      = KIND_CURLY;
      end
      CHAR_ROUND_CLOSE: begin
        closer = 1'b1;
        k      = KIND_ROUND;
      end
      CHAR_SQUARE_CLOSE: begin
        closer = 1'b1;
        k      = KIND_SQUARE;
      end
      CHAR_CURLY_CLOSE: begin
        closer = 1'b1;
        k      = KIND_CURLY;
      end
      default: ;
    endcase
    if (latched_err == STATUS_BALANCED) begin
      if (opener) begin
        if (nest_level >= STACK_DEPTH) begin
          latched_err = STATUS_OVERFLOW;
        end else begin
          nest_stack[nest_level] = k;
          nest_level++;
        end
      end else if (closer) begin
        if (nest_level == 0) begin
          latched_err = STATUS_MISMATCH;
        end else if (nest_stack[nest_level - 1] != k) begin
          latched_err = STATUS_MISMATCH;
        end else begin
          nest_level--;
        end
      end
    end
    if (l) begin
      if (latched_err != STATUS_BALANCED) begin
        status_queue.push_back(latched_err);
      end else if (nest_level != 0) begin
        status_queue.push_back(STATUS_UNCLOSED);
      end else begin
        status_queue.push_back(STATUS_BALANCED);
      end
      nest_level  = 0;
      latched_err = STATUS_BALANCED;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      nest_level  = 0;
      latched_err = STATUS_BALANCED;
      status_queue.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (status_queue.size() == 0) begin
          $error("status: expected none, actual %0d", result.status);
          fails++;
        end else begin
          oldest = status_queue.pop_front();
          if (result.status !== oldest) begin
            $error("status: expected %0d, actual %0d", oldest, result.status);
            fails++;
          end
        end
      end
      if (chars.valid && chars.ready) begin
        apply_byte(chars.character, chars.last);
      end
    end
    waiting = status_queue.size();
  end

endmodule

// File: tb/sv/tb_bracket_nesting_checker_core.sv
`timescale 1ns / 1ps
module tb_bracket_nesting_checker_core;
  import bnc_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int ITEM_TARGET = 1600;

  logic       clk;
  logic       rst;
  int         fails;
  int         waiting;
  int         cycles;
  int         sent_items;
  bit         steady;
  logic [7:0] line_bytes [$];

  bnc_char_if   chars ();
  bnc_status_if result ();

  bracket_nesting_checker_core dut (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .result(result)
  );

  bracket_status_checker status_chk (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars),
    .result (result),
    .fails  (fails),
    .waiting(waiting)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_bracket_nesting_checker_core NOT OK");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit is_bracket(input logic [7:0] c);
    return c == CHAR_ROUND_OPEN || c == CHAR_SQUARE_OPEN || c == CHAR_CURLY_OPEN ||
           c == CHAR_ROUND_CLOSE || c == CHAR_SQUARE_CLOSE || c == CHAR_CURLY_CLOSE;
  endfunction

  function automatic logic [7:0] open_char(input kind_t k);
    case (k)
      KIND_ROUND:  return CHAR_ROUND_OPEN;
      KIND_SQUARE: return CHAR_SQUARE_OPEN;
      default:     return CHAR_CURLY_OPEN;
    endcase
  endfunction

  function automatic logic [7:0] close_char(input kind_t k);
    case (k)
      KIND_ROUND:  return CHAR_ROUND_CLOSE;
      KIND_SQUARE: return CHAR_SQUARE_CLOSE;
      default:     return CHAR_CURLY_CLOSE;
    endcase
  endfunction

  function automatic kind_t close_kind(input logic [7:0] c);
    case (c)
      CHAR_ROUND_CLOSE:  return KIND_ROUND;
      CHAR_SQUARE_CLOSE: return KIND_SQUARE;
      default:           return KIND_CURLY;
    endcase
  endfunction

  function automatic kind_t any_kind();
    return kind_t'($urandom_range(int'(KIND_ROUND), int'(KIND_CURLY)));
  endfunction

  function automatic logic [7:0] filler();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (is_bracket(c)) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  initial begin
    int stall;
    result.ready = 1'b0;
    stall        = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        result.ready <= 1'b0;
        stall--;
      end else begin
        result.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic l);
    int gap;
    chars.valid     <= 1'b1;
    chars.character <= c;
    chars.last      <= l;
    @(posedge clk);
    while (!chars.ready) @(posedge clk);
    sent_items++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      chars.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_bytes.size(); i++) begin
      send_byte(line_bytes[i], i == line_bytes.size() - 1);
    end
  endtask

  task automatic make_nested(input int max_depth, input int steps);
    kind_t open_kinds [$];
    kind_t k;
    int    r;
    line_bytes.delete();
    for (int i = 0; i < steps; i++) begin
      r = $urandom_range(0, 9);
      if (r < 4 && open_kinds.size() < max_depth) begin
        k = any_kind();
        open_kinds.push_back(k);
        line_bytes.push_back(open_char(k));
      end else if (r < 8 && open_kinds.size() > 0) begin
        line_bytes.push_back(close_char(open_kinds.pop_back()));
      end else begin
        line_bytes.push_back(filler());
      end
    end
    while (open_kinds.size() > 0) line_bytes.push_back(close_char(open_kinds.pop_back()));
    if (line_bytes.size() == 0) line_bytes.push_back(filler());
  endtask

  task automatic make_full(input int openers);
    kind_t open_kinds [$];
    kind_t k;
    line_bytes.delete();
    for (int i = 0; i < openers; i++) begin
      k = any_kind();
      open_kinds.push_back(k);
      line_bytes.push_back(open_char(k));
      if ($urandom_range(0, 5) == 0) line_bytes.push_back(filler());
    end
    while (open_kinds.size() > 0) line_bytes.push_back(close_char(open_kinds.pop_back()));
  endtask

  task automatic make_mismatch();
    int closers [$];
    int p;
    for (int i = 0; i < line_bytes.size(); i++) begin
      if (is_bracket(line_bytes[i]) && line_bytes[i] != open_char(close_kind(line_bytes[i])) &&
          line_bytes[i] == close_char(close_kind(line_bytes[i]))) begin
        closers.push_back(i);
      end
    end
    if (closers.size() == 0) begin
      line_bytes.push_back(close_char(any_kind()));
    end else begin
      p = closers[$urandom_range(0, closers.size() - 1)];
      line_bytes[p] = close_char(kind_t'((int'(close_kind(line_bytes[p])) +
                                          $urandom_range(1, 2)) % 3));
    end
  endtask

  task automatic make_noise();
    int n;
    line_bytes.delete();
    n = $urandom_range(1, 16);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 2))
        0:       line_bytes.push_back(open_char(any_kind()));
        1:       line_bytes.push_back(close_char(any_kind()));
        default: line_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  initial begin
    int r;
    int depth;
    int line_no;
    rst             = 1'b1;
    chars.valid     = 1'b0;
    chars.character = 8'h00;
    chars.last      = 1'b0;
    steady          = 1'b0;
    sent_items      = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_text("()");
    send_text("[{}]");
    send_text("(]x)");
    send_text(")");
    send_text("{(");
    send_text("((]");
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_text("{[()]}");

    line_no = 0;
    while (sent_items < ITEM_TARGET) begin
      steady = ($urandom_range(0, 4) == 0);
      r      = $urandom_range(0, 99);
      if (line_no == 0) r = 83;
      if (line_no == 1) r = 79;
      depth = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
      if (r < 55) begin
        make_nested(depth, $urandom_range(1, 4 * depth + 8));
      end else if (r < 65) begin
        make_nested(depth, $urandom_range(2, 4 * depth + 8));
        make_mismatch();
      end else if (r < 72) begin
        make_nested(depth, $urandom_range(1, 4 * depth + 8));
        line_bytes.insert($urandom_range(0, line_bytes.size()), open_char(any_kind()));
      end else if (r < 78) begin
        make_nested(depth, $urandom_range(1, 4 * depth + 8));
        line_bytes.insert($urandom_range(0, line_bytes.size()), close_char(any_kind()));
      end else if (r < 82) begin
        make_full(STACK_DEPTH);
      end else if (r < 86) begin
        make_full(STACK_DEPTH + $urandom_range(1, 4));
      end else begin
        make_noise();
      end
      send_line();
      line_no++;
    end
    chars.valid <= 1'b0;
    steady = 1'b0;

    while (waiting != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fails == 0) begin
      $display("tb_bracket_nesting_checker_core OK");
    end else begin
      $display("tb_bracket_nesting_checker_core NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/bnc_pkg.sv
sv/bnc_char_if.sv
sv/bnc_status_if.sv
sv/bnc_cell.sv
sv/bracket_nesting_checker_core.sv
tb/sv/bracket_status_checker.sv
tb/sv/tb_bracket_nesting_checker_core.sv
